### hw/rtl/cca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cca_pkg: shared types and constants for the canonical code assigner
// Table sizes, field widths, command codes, FSM states and the control
// bundle that drives the shared code counter.
// ----------------------------------------------------------------------------
package cca_pkg;

  // Table and field sizes
  localparam int NUM_SYMBOLS  = 256;
  localparam int MAX_CODE_LEN = 16;
  localparam int SYM_W        = 8;
  localparam int IDX_W        = $clog2(NUM_SYMBOLS);
  localparam int LEN_W        = 5;
  localparam int CODE_W       = 16;
  localparam int LEN_MAX      = (1 << LEN_W) - 1;

  // Counter stays below 2^width and width never passes LEN_MAX + 1
  localparam int CNT_W        = LEN_MAX + 2;
  localparam int WID_W        = $clog2(CNT_W + 1);

  // Stream packing
  localparam int S_DATA_W     = ((SYM_W + LEN_W + 7) / 8) * 8;
  localparam int M_DATA_W     = ((CODE_W + LEN_W + 7) / 8) * 8;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_LOOK,
    ST_RESP
  } state_t;

  // Control bundle for the code counter
  typedef struct packed {
    logic             clear;
    logic             step;
    logic             hit;
    logic [LEN_W-1:0] len;
  } cca_step_t;

endpackage

### hw/rtl/cca_len_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cca_len_mem: code length table
// One write port, one registered read port. Per-entry valid bits cleared by
// reset make unwritten entries read as length zero.
// ----------------------------------------------------------------------------
module cca_len_mem
  import cca_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  logic [LEN_W-1:0] wdata,
  input  logic [IDX_W-1:0] raddr,
  output logic [LEN_W-1:0] rdata
);

  logic [LEN_W-1:0]       mem [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] vld;
  logic [LEN_W-1:0]       mem_q;
  logic                   vld_q;

  // Store a length
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Track written entries
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    mem_q <= mem[raddr];
    vld_q <= vld[raddr];
  end

  assign rdata = vld_q ? mem_q : '0;

endmodule

### hw/rtl/cca_code_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cca_code_mem: canonical code table
// One write port filled during the rebuild sweep, one registered read port.
// ----------------------------------------------------------------------------
module cca_code_mem
  import cca_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  logic [CODE_W-1:0] wdata,
  input  logic [IDX_W-1:0]  raddr,
  output logic [CODE_W-1:0] rdata
);

  logic [CODE_W-1:0] mem [NUM_SYMBOLS];

  // Store a code
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/cca_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cca_counter: shared canonical code counter
// Each step widens the counter by one bit while its width is below the
// current length, then on a hit hands out the code, increments and grows
// the width when the low width bits roll over to zero.
// ----------------------------------------------------------------------------
module cca_counter
  import cca_pkg::*;
(
  input  logic              clk,
  input  cca_step_t         ctl,
  output logic [CODE_W-1:0] code
);

  localparam logic [CNT_W-1:0] KEEP = (CNT_W'(1) << MAX_CODE_LEN) - CNT_W'(1);

  logic [CNT_W-1:0] counter;
  logic [WID_W-1:0] width;
  logic             grow;
  logic [CNT_W-1:0] cnt_sh;
  logic [WID_W-1:0] wid_sh;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] low_mask;
  logic             roll;
  logic [CNT_W-1:0] counter_next;
  logic [WID_W-1:0] width_next;

  // Widen by one bit when below the current length
  always_comb begin
    grow   = width < WID_W'(ctl.len);
    cnt_sh = grow ? {counter[CNT_W-2:0], 1'b0} : counter;
    wid_sh = grow ? width + WID_W'(1) : width;
  end

  // Increment and test the low width bits
  always_comb begin
    cnt_inc  = cnt_sh + CNT_W'(1);
    low_mask = (32'(wid_sh) >= CNT_W) ? '1 : (CNT_W'(1) << wid_sh) - CNT_W'(1);
    roll     = (cnt_inc & low_mask) == '0;
  end

  // Select the next counter state
  always_comb begin
    counter_next = counter;
    width_next   = width;
    if (ctl.clear) begin
      counter_next = '0;
      width_next   = '0;
    end else if (ctl.step) begin
      counter_next = ctl.hit ? cnt_inc : cnt_sh;
      width_next   = (ctl.hit && roll) ? wid_sh + WID_W'(1) : wid_sh;
    end
  end

  always_ff @(posedge clk) begin
    counter <= counter_next;
    width   <= width_next;
  end

  assign code = CODE_W'(cnt_sh & KEEP);

endmodule

### hw/rtl/canonical_code_assigner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canonical_code_assigner_top: canonical code assigner
// Length table writes and canonical code reads over a stream interface.
// ----------------------------------------------------------------------------
// Input beats carry a command in s_tuser: a write stores the code length of
// one symbol and returns nothing; a read returns one output beat with the
// symbol's canonical code, its stored length and a present flag in m_tuser.
// A read goes straight to the response state when the code table is up to
// date. The first read after any write first rebuilds the code table: one
// sweep over every length from 1 to 31 and every symbol, one table entry per
// cycle through the shared code counter.
// s_tready is high only while the sequencer is idle.
// Reset empties the length table (all lengths read as zero) and marks the
// code table out of date; no clearing pass is needed.
// The result sits in an output register; a stalled receiver holds it while
// the next input beat is still taken, and a second read waits in the
// response state until the register is free.
// ----------------------------------------------------------------------------
module canonical_code_assigner_top
  import cca_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // symbol[7:0], length[12:8]
  input  logic [0:0]          s_tuser,   // command[0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // code[15:0], code_length[20:16]
  output logic [0:0]          m_tuser    // present[0]
);

  state_t            state;
  state_t            state_next;

  logic              s_acc;
  logic [SYM_W-1:0]  in_sym;
  logic [LEN_W-1:0]  in_len;
  logic              in_ok;
  logic              is_read;
  logic              stale;

  logic [IDX_W-1:0]  req_sym;
  logic              req_ok;

  logic [IDX_W-1:0]  scan_sym;
  logic [LEN_W-1:0]  scan_len;
  logic              scan_last;

  logic              dv_valid;
  logic [IDX_W-1:0]  dv_sym;
  logic [LEN_W-1:0]  dv_len;

  logic              len_we;
  logic [IDX_W-1:0]  rd_addr;
  logic [LEN_W-1:0]  len_rd;
  logic [CODE_W-1:0] code_rd;
  logic              code_we;
  logic [CODE_W-1:0] code_wr;
  cca_step_t         cnt_ctl;

  logic              scan_on;
  logic              out_free;
  logic              load_out;

  logic [CODE_W-1:0] out_code;
  logic [LEN_W-1:0]  out_len;
  logic              out_present;

  // Unpack the input beat
  assign in_sym  = s_tdata[SYM_W-1:0];
  assign in_len  = s_tdata[SYM_W+LEN_W-1:SYM_W];
  assign in_ok   = 32'(in_sym) < NUM_SYMBOLS;
  assign is_read = cmd_t'(s_tuser[0]) == CMD_READ;
  assign s_acc   = s_tvalid && s_tready;

  assign scan_last = (scan_len == LEN_W'(LEN_MAX)) &&
                     (scan_sym == IDX_W'(NUM_SYMBOLS - 1));
  assign out_free  = !m_tvalid || m_tready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_acc && is_read) begin
          state_next = stale ? ST_SCAN : ST_RESP;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_LOOK;
      ST_LOOK:  state_next = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready = 1'b0;
    scan_on  = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE:  s_tready = 1'b1;
      ST_SCAN:  scan_on  = 1'b1;
      ST_DRAIN: ;
      ST_LOOK:  ;
      ST_RESP:  load_out = out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Mark codes out of date on writes, fresh after the sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      stale <= 1'b1;
    end else if (s_acc && !is_read && in_ok) begin
      stale <= 1'b1;
    end else if (state == ST_DRAIN) begin
      stale <= 1'b0;
    end
  end

  // Capture the read request
  always_ff @(posedge clk) begin
    if (s_acc && is_read) begin
      req_sym <= IDX_W'(in_sym);
      req_ok  <= in_ok;
    end
  end

  // Advance the sweep address: symbols inside, lengths outside
  always_ff @(posedge clk) begin
    if (s_acc && is_read) begin
      scan_sym <= '0;
      scan_len <= LEN_W'(1);
    end else if (scan_on) begin
      scan_sym <= scan_sym + IDX_W'(1);
      if (scan_sym == IDX_W'(NUM_SYMBOLS - 1)) begin
        scan_len <= scan_len + LEN_W'(1);
      end
    end
  end

  // Data stage of the sweep, aligned with the registered table read
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid <= 1'b0;
    end else begin
      dv_valid <= scan_on;
    end
  end

  always_ff @(posedge clk) begin
    dv_sym <= scan_sym;
    dv_len <= scan_len;
  end

  // Table read address
  always_comb begin
    priority if (scan_on) begin
      rd_addr = scan_sym;
    end else if (state == ST_IDLE) begin
      rd_addr = IDX_W'(in_sym);
    end else begin
      rd_addr = req_sym;
    end
  end

  assign len_we = s_acc && !is_read && in_ok;

  cca_len_mem u_len_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (len_we),
    .waddr (IDX_W'(in_sym)),
    .wdata (in_len),
    .raddr (rd_addr),
    .rdata (len_rd)
  );

  // Drive the shared counter
  always_comb begin
    cnt_ctl.clear = s_acc && is_read && stale;
    cnt_ctl.step  = dv_valid;
    cnt_ctl.hit   = dv_valid && (len_rd == dv_len);
    cnt_ctl.len   = dv_len;
  end

  cca_counter u_counter (
    .clk  (clk),
    .ctl  (cnt_ctl),
    .code (code_wr)
  );

  assign code_we = cnt_ctl.hit;

  cca_code_mem u_code_mem (
    .clk   (clk),
    .we    (code_we),
    .waddr (dv_sym),
    .wdata (code_wr),
    .raddr (rd_addr),
    .rdata (code_rd)
  );

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (req_ok && (len_rd != '0)) begin
        out_code    <= code_rd;
        out_len     <= len_rd;
        out_present <= 1'b1;
      end else begin
        out_code    <= '0;
        out_len     <= '0;
        out_present <= 1'b0;
      end
    end
  end

  assign m_tdata    = {(M_DATA_W - CODE_W - LEN_W)'(0), out_len, out_code};
  assign m_tuser[0] = out_present;

`ifndef SYNTHESIS
  a_code_we_in_sweep : assert property (@(posedge clk) disable iff (rst)
    code_we |-> (state == ST_SCAN || state == ST_DRAIN))
    else $error("code table written outside the rebuild sweep");

  a_result_from_resp : assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_RESP)
    else $error("result raised outside the response state");

  a_stale_read_sweeps : assert property (@(posedge clk) disable iff (rst)
    (s_acc && is_read && stale) |=> state == ST_SCAN)
    else $error("read of out-of-date codes skipped the rebuild");

  a_sweep_clears_stale : assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |=> !stale)
    else $error("codes still marked out of date after the sweep");

  a_write_clean : assert property (@(posedge clk) disable iff (rst)
    len_we |-> state == ST_IDLE && !scan_on)
    else $error("length table written while busy");
`endif

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for canonical_code_assigner_top
// Feeds length writes and code reads through the input stream, keeps a
// shadow length table and rebuilds canonical codes on its own, and compares
// every output beat field by field against the oldest predicted code.
// ----------------------------------------------------------------------------
module tb;
  import cca_pkg::*;

  // One input beat; hold makes the sender wait until all codes are back
  typedef struct {
    cmd_t             cmd;
    logic [SYM_W-1:0] sym;
    logic [LEN_W-1:0] len;
    bit               hold;
  } cca_req_t;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  code_length;
    logic              present;
  } code_result_t;

  localparam int RANDOM_ITEMS = 750;
  localparam int DRAIN_CYCLES = 100;
  localparam int REBUILD_COST = 8000;

  logic                clk;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;   // symbol[7:0], length[12:8]
  logic [0:0]          s_tuser  = '0;   // command[0]
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;         // code[15:0], code_length[20:16]
  logic [0:0]          m_tuser;         // present[0]

  cca_req_t     pending_q[$];
  code_result_t code_expect_q[$];
  cca_req_t     cur_req;

  // Shadow of the block state, updated as beats are accepted
  logic [LEN_W-1:0]  len_shadow [NUM_SYMBOLS];
  logic [CODE_W-1:0] code_shadow[NUM_SYMBOLS];
  bit                codes_outdated;

  // Generator-side view, used only to shape stimulus and size the timeout
  int  gen_len[NUM_SYMBOLS];
  bit  gen_outdated = 1'b1;
  int  gen_rebuilds = 0;
  int  gen_items    = 0;

  longint unsigned cycle_cnt   = 0;
  longint unsigned cycle_limit = 0;
  bit  quiet = 1'b0;
  int  gap_left;
  int  stall_left;
  int  err_cnt = 0;

  canonical_code_assigner_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short idles, a few long ones, none while in a quiet stretch
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, field, got, want);
    err_cnt++;
  endtask

  // Walk lengths 1..31 and symbols in order, handing out codes from a
  // 64-bit counter that shifts up to each length and widens on rollover
  function automatic void rebuild_code_shadow();
    logic [63:0] counter;
    logic [63:0] wmask;
    logic [63:0] keep;
    int          width;
    counter = '0;
    width   = 0;
    keep    = (64'd1 << MAX_CODE_LEN) - 64'd1;
    for (int s = 0; s < NUM_SYMBOLS; s++) code_shadow[s] = '0;
    for (int l = 1; l <= LEN_MAX; l++) begin
      for (int s = 0; s < NUM_SYMBOLS; s++) begin
        if (len_shadow[s] != l) continue;
        while (width < l) begin
          counter = counter << 1;
          width++;
        end
        code_shadow[s] = CODE_W'(counter & keep);
        counter = counter + 64'd1;
        wmask = (width >= 64) ? '1 : ((64'd1 << width) - 64'd1);
        if ((counter & wmask) == '0) width++;
      end
    end
    codes_outdated = 1'b0;
  endfunction

  // Apply one accepted beat to the shadow; reads queue their expected code
  function automatic void predict_code(cca_req_t r);
    code_result_t e;
    if (r.cmd == CMD_WRITE) begin
      if (r.sym < NUM_SYMBOLS) begin
        len_shadow[r.sym] = r.len;
        codes_outdated = 1'b1;
      end
      return;
    end
    if (codes_outdated) rebuild_code_shadow();
    if (r.sym < NUM_SYMBOLS && len_shadow[r.sym] != '0) begin
      e.code        = code_shadow[r.sym];
      e.code_length = len_shadow[r.sym];
      e.present     = 1'b1;
    end else begin
      e.code        = '0;
      e.code_length = '0;
      e.present     = 1'b0;
    end
    code_expect_q.push_back(e);
  endfunction

  // Queue a beat and track how many table rebuilds it will cost
  function automatic void add_req(cmd_t c, int sym, int len, bit hold);
    cca_req_t r;
    r.cmd  = c;
    r.sym  = sym[SYM_W-1:0];
    r.len  = len[LEN_W-1:0];
    r.hold = hold;
    pending_q.push_back(r);
    gen_items++;
    if (c == CMD_WRITE) begin
      gen_len[sym]  = len;
      gen_outdated  = 1'b1;
    end else if (gen_outdated) begin
      gen_rebuilds++;
      gen_outdated = 1'b0;
    end
  endfunction

  // Reads mostly target coded symbols, sometimes any symbol
  function automatic int pick_read_sym();
    int coded[$];
    for (int s = 0; s < NUM_SYMBOLS; s++)
      if (gen_len[s] != 0) coded.push_back(s);
    if (coded.size() != 0 && $urandom_range(0, 99) < 75)
      return coded[$urandom_range(0, coded.size() - 1)];
    return $urandom_range(0, NUM_SYMBOLS - 1);
  endfunction

  function automatic int pick_noise_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 30) return $urandom_range(MAX_CODE_LEN + 1, LEN_MAX);
    if (r < 50) return $urandom_range(1, 3);
    return $urandom_range(4, MAX_CODE_LEN);
  endfunction

  // Count cycles, flip quiet stretches, and stop on a hang
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt % 256 == 0) quiet <= ($urandom_range(0, 3) == 0);
    if (cycle_limit != 0 && cycle_cnt >= cycle_limit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Driver: present queued beats, predict each one as it is taken
  always @(posedge clk) begin
    bit live;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= '0;
      gap_left = 0;
      for (int s = 0; s < NUM_SYMBOLS; s++) begin
        len_shadow[s]  = '0;
        code_shadow[s] = '0;
      end
      codes_outdated = 1'b1;
    end else begin
      live = s_tvalid;
      if (s_tvalid && s_tready) begin
        predict_code(cur_req);
        live = 1'b0;
        gap_left = pick_idle();
      end
      if (!live) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() != 0 &&
                     !(pending_q[0].hold && code_expect_q.size() != 0)) begin
          cur_req = pending_q.pop_front();
          live = 1'b1;
          s_tdata <= S_DATA_W'({cur_req.len, cur_req.sym});
          s_tuser <= cur_req.cmd;
        end
      end
      s_tvalid <= live;
    end
  end

  // Monitor: compare each output beat with the oldest predicted code
  always @(posedge clk) begin
    code_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (code_expect_q.size() == 0) begin
          report_mismatch("unexpected beat", m_tdata, 0);
        end else begin
          want = code_expect_q.pop_front();
          if (m_tdata[CODE_W-1:0] !== want.code)
            report_mismatch("code", m_tdata[CODE_W-1:0], want.code);
          if (m_tdata[CODE_W +: LEN_W] !== want.code_length)
            report_mismatch("code_length", m_tdata[CODE_W +: LEN_W], want.code_length);
          if (m_tuser[0] !== want.present)
            report_mismatch("present", m_tuser[0], want.present);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 99) < 30) stall_left = pick_idle();
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int rand_start;
    int phase;
    int k;
    int idx;
    int d;
    int sym;
    int leaves[$];

    for (int s = 0; s < NUM_SYMBOLS; s++) gen_len[s] = 0;

    // Directed: empty table, shared short lengths past the Kraft bound,
    // out-of-range lengths, overwrite, excluded symbols, field extremes
    add_req(CMD_READ,  0,   0,  1'b0);
    add_req(CMD_WRITE, 0,   1,  1'b0);
    add_req(CMD_WRITE, 255, 1,  1'b0);
    add_req(CMD_WRITE, 128, 1,  1'b0);
    add_req(CMD_WRITE, 7,   16, 1'b0);
    add_req(CMD_WRITE, 200, 31, 1'b0);
    add_req(CMD_WRITE, 100, 17, 1'b0);
    add_req(CMD_WRITE, 100, 20, 1'b0);
    add_req(CMD_WRITE, 50,  0,  1'b0);
    add_req(CMD_READ,  0,   0,  1'b0);
    add_req(CMD_READ,  255, 0,  1'b0);
    add_req(CMD_READ,  128, 0,  1'b0);
    add_req(CMD_READ,  7,   0,  1'b0);
    add_req(CMD_READ,  200, 0,  1'b0);
    add_req(CMD_READ,  100, 31, 1'b0);
    add_req(CMD_READ,  50,  0,  1'b0);
    add_req(CMD_READ,  3,   0,  1'b0);
    add_req(CMD_WRITE, 255, 0,  1'b0);
    add_req(CMD_READ,  255, 0,  1'b0);
    add_req(CMD_READ,  0,   0,  1'b0);
    add_req(CMD_WRITE, 1,   31, 1'b0);
    add_req(CMD_WRITE, 2,   16, 1'b0);
    add_req(CMD_READ,  1,   0,  1'b0);
    add_req(CMD_READ,  2,   0,  1'b0);

    // Random phases: a burst of writes, then a run of reads
    rand_start = gen_items;
    phase = 0;
    while (gen_items - rand_start < RANDOM_ITEMS) begin
      phase++;
      if ($urandom_range(0, 1) == 0) begin
        // Well-formed: drop the old code, then load a complete prefix code
        for (int s = 0; s < NUM_SYMBOLS; s++)
          if (gen_len[s] != 0) add_req(CMD_WRITE, s, 0, 1'b0);
        k = $urandom_range(2, 16);
        leaves = {0};
        repeat (k - 1) begin
          do idx = $urandom_range(0, leaves.size() - 1);
          while (leaves[idx] >= MAX_CODE_LEN);
          d = leaves[idx] + 1;
          leaves[idx] = d;
          leaves.push_back(d);
        end
        foreach (leaves[i]) begin
          do sym = $urandom_range(0, NUM_SYMBOLS - 1); while (gen_len[sym] != 0);
          add_req(CMD_WRITE, sym, leaves[i], 1'b0);
        end
      end else begin
        // Noise: arbitrary lengths, including zero and above range
        repeat ($urandom_range(1, 12))
          add_req(CMD_WRITE, $urandom_range(0, NUM_SYMBOLS - 1), pick_noise_len(), 1'b0);
      end
      // Pause the sender now and then until every code is back
      add_req(CMD_READ, pick_read_sym(), $urandom_range(0, LEN_MAX),
              (phase == 1 || phase % 5 == 0));
      repeat ($urandom_range(4, 20))
        add_req(CMD_READ, pick_read_sym(), $urandom_range(0, LEN_MAX), 1'b0);
      // Sometimes interleave writes and reads, forcing back-to-back rebuilds
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(2, 3)) begin
          add_req(CMD_WRITE, $urandom_range(0, NUM_SYMBOLS - 1), pick_noise_len(), 1'b0);
          add_req(CMD_READ, pick_read_sym(), 0, 1'b0);
        end
      end
    end

    cycle_limit = 4 * (longint'(gen_rebuilds) * REBUILD_COST + longint'(gen_items) * 130)
                  + 50000;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending_q.size() != 0 || s_tvalid || code_expect_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/cca_pkg.sv
hw/rtl/cca_len_mem.sv
hw/rtl/cca_code_mem.sv
hw/rtl/cca_counter.sv
hw/rtl/canonical_code_assigner_top.sv
test/tb.sv
